@@ design/xtea_pkg.sv @@
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, constants and round function of the XTEA nibble stream
// encryptor.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int ROUND_CYCLES = 2;
  localparam int RND_W = $clog2(ROUND_CYCLES + 1);

  localparam int BLOCK_LEN = 8;
  localparam int FILL_W = $clog2(BLOCK_LEN);

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_DELTA = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY3 = 3'd4;

  localparam logic [31:0] DELTA_RESET = 32'h0000_0000;
  localparam logic [31:0] KEY0_RESET = 32'h3246_4741;
  localparam logic [31:0] KEY1_RESET = 32'h1113_1519;
  localparam logic [31:0] KEY2_RESET = 32'h2623_2528;
  localparam logic [31:0] KEY3_RESET = 32'h4245_4649;

  localparam logic [31:0] SHIFT_MASK = 32'h07ff_ffff;
  localparam logic [7:0] NIBBLE_BASE = 8'h30;
  localparam logic [7:0] TERMINATOR = 8'hFA;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } xtea_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } xtea_out_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       round_a;
    logic       round_b;
    logic       emit_char;
    logic       emit_term;
    logic [3:0] nib_idx;
  } xtea_cmd_t;

  typedef struct packed {
    logic block_full;
  } xtea_sts_t;

  function automatic logic [31:0] xtea_f(input logic [31:0] x, input logic [31:0] s,
                                         input logic [31:0] k);
    logic [31:0] mixed;
    mixed = ((x << 4) ^ ((x >> 5) & SHIFT_MASK)) + x;
    return mixed ^ (s + k);
  endfunction

endpackage

@@ design/xtea_ctrl.sv @@
// ----------------------------------------------------------------------------
// xtea_ctrl
// Controller: sequences byte collection, the cipher rounds, the character
// emission and the terminator, and owns the output valid flag.
// ----------------------------------------------------------------------------
module xtea_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  xtea_pkg::xtea_sts_t sts,
  output xtea_pkg::xtea_cmd_t cmd
);
  import xtea_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_RNDA = 3'd2;
  localparam logic [2:0] S_RNDB = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_TERM = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [RND_W-1:0] rnd;
  logic [RND_W-1:0] rnd_next;
  logic [3:0]       nib;
  logic [3:0]       nib_next;
  logic             last_flag;
  logic             last_flag_next;
  logic             out_valid_next;
  logic             out_free;
  logic             in_xfer;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    rnd_next       = rnd;
    nib_next       = nib;
    last_flag_next = last_flag;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.nib_idx    = nib;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.accept     = 1'b1;
          last_flag_next = in_last;
          if (in_last || sts.block_full) begin
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        rnd_next   = '0;
        state_next = S_RNDA;
      end
      S_RNDA: begin
        cmd.round_a = 1'b1;
        state_next  = S_RNDB;
      end
      S_RNDB: begin
        cmd.round_b = 1'b1;
        if (rnd == RND_W'(ROUND_CYCLES - 1)) begin
          nib_next   = '0;
          state_next = S_EMIT;
        end else begin
          rnd_next   = rnd + 1'b1;
          state_next = S_RNDA;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit_char  = 1'b1;
          out_valid_next = 1'b1;
          nib_next       = nib + 1'b1;
          if (nib == 4'd15) begin
            state_next = last_flag ? S_TERM : S_IDLE;
          end
        end
      end
      S_TERM: begin
        if (out_free) begin
          cmd.emit_term  = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rnd       <= '0;
      nib       <= '0;
      last_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      nib       <= nib_next;
      last_flag <= last_flag_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ design/xtea_dp.sv @@
// ----------------------------------------------------------------------------
// xtea_dp
// Datapath: configuration registers, block buffer, one half-round unit and
// the output character register.
// ----------------------------------------------------------------------------
module xtea_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [xtea_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                        cfg_data,
  input  xtea_pkg::xtea_in_t                 in_data,
  input  xtea_pkg::xtea_cmd_t                cmd,
  output xtea_pkg::xtea_sts_t                sts,
  output xtea_pkg::xtea_out_t                out_data
);
  import xtea_pkg::*;

  logic [31:0]       delta;
  logic [31:0]       key_word [4];
  logic [7:0]        block_bytes [BLOCK_LEN];
  logic [FILL_W-1:0] fill;
  logic [31:0]       v0;
  logic [31:0]       v1;
  logic [31:0]       sum;
  logic [1:0]        key_sel;
  logic [31:0]       f_out;
  logic [63:0]       cipher;
  logic [3:0]        nib_val;
  logic [3:0]        nib_pos;

  assign sts.block_full = (fill == FILL_W'(BLOCK_LEN - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      delta       <= DELTA_RESET;
      key_word[0] <= KEY0_RESET;
      key_word[1] <= KEY1_RESET;
      key_word[2] <= KEY2_RESET;
      key_word[3] <= KEY3_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DELTA: delta       <= cfg_data;
        REG_KEY0:  key_word[0] <= cfg_data;
        REG_KEY1:  key_word[1] <= cfg_data;
        REG_KEY2:  key_word[2] <= cfg_data;
        REG_KEY3:  key_word[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int i = 0; i < BLOCK_LEN; i++) begin
        block_bytes[i] <= '0;
      end
    end else if (cmd.accept) begin
      block_bytes[fill] <= in_data.in_byte;
      fill              <= fill + 1'b1;
    end else if (cmd.load) begin
      fill <= '0;
      for (int i = 0; i < BLOCK_LEN; i++) begin
        block_bytes[i] <= '0;
      end
    end
  end

  assign key_sel = cmd.round_b ? sum[12:11] : sum[1:0];
  assign f_out   = xtea_f(cmd.round_b ? v0 : v1, sum, key_word[key_sel]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v0  <= {block_bytes[3], block_bytes[2], block_bytes[1], block_bytes[0]};
      v1  <= {block_bytes[7], block_bytes[6], block_bytes[5], block_bytes[4]};
      sum <= '0;
    end else if (cmd.round_a) begin
      v0  <= v0 + f_out;
      sum <= sum + delta;
    end else if (cmd.round_b) begin
      v1 <= v1 + f_out;
    end
  end

  assign cipher  = {v1, v0};
  assign nib_pos = {cmd.nib_idx[3:1], ~cmd.nib_idx[0]};
  assign nib_val = cipher[{nib_pos, 2'b00} +: 4];

  always_ff @(posedge clk) begin
    if (cmd.emit_char) begin
      out_data.out_char <= {4'd0, nib_val} + NIBBLE_BASE;
      out_data.out_last <= 1'b0;
    end else if (cmd.emit_term) begin
      out_data.out_char <= TERMINATOR;
      out_data.out_last <= 1'b1;
    end
  end

endmodule

@@ design/xtea_nibble_stream_encryptor_core.sv @@
// ----------------------------------------------------------------------------
// xtea_nibble_stream_encryptor_core
// Collects message bytes into 8-byte blocks, encrypts each block with
// ROUND_CYCLES rounds of XTEA and sends the cipher text as nibble characters.
//
// Input channel (in_valid/in_ready/in_data) takes one byte per transfer with
// a last flag. Output channel (out_valid/out_ready/out_data) delivers one
// character per transfer: 0x30..0x3F per nibble, and 0xFA with out_last set
// after the final block of a message. The configuration channel writes the
// delta (index 0) and key words 0..3 (indexes 1..4); other indexes are
// ignored, and writes are always taken.
// A byte that does not complete a block is accepted in the idle state. A
// completing or last byte is followed by the block load, ROUND_CYCLES rounds
// of the single half-round unit, then 16 output transfers (17 with the
// terminator), one per cycle while the receiver is ready. No new byte is
// taken until the last character of the block is in the output register.
// A stalled receiver holds the output register and stops emission.
// Reset restores the default key, zero delta and an empty block buffer.
// ----------------------------------------------------------------------------
module xtea_nibble_stream_encryptor_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  xtea_pkg::xtea_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output xtea_pkg::xtea_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [xtea_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);
  import xtea_pkg::*;

  xtea_cmd_t cmd;
  xtea_sts_t sts;

  assign cfg_ready = 1'b1;

  xtea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.in_last),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  xtea_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/xtea_nibble_stream_encryptor_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_nibble_stream_encryptor_core_tb
// Self-checking testbench for the XTEA nibble stream encryptor core.
//
// Message bytes are sent over the input channel in random bursts while the
// receiver stalls on its own pattern. A cipher model inside the testbench
// follows every accepted byte and queues the characters the core must send;
// each output transfer is checked against the oldest queued character.
// The run covers reset defaults, extreme keys and deltas, ignored register
// indexes, a long receiver hold-off and several random configurations.
// ----------------------------------------------------------------------------
module xtea_nibble_stream_encryptor_core_tb;
  import xtea_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 4 * ROUND_CYCLES + 12;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int RUN_LIMIT = 1000000;
  localparam int MAX_PRINTS = 40;
  localparam int RANDOM_BYTES = 360;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_INDEX = '1;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  xtea_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  xtea_out_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  logic [31:0] cipher_delta;
  logic [31:0] cipher_key [4];
  logic [7:0]  plain_block [8];
  int          plain_fill;
  xtea_out_t   expected_chars [$];

  rx_mode_t rx_mode = RX_ALWAYS;
  int       hold_total = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       rx_tick = 0;

  int burst_left = 0;
  bit gapless = 1'b0;

  int err_cnt = 0;
  int bytes_sent = 0;
  int msgs_sent = 0;
  int chars_checked = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int run_cycles = 0;

  xtea_nibble_stream_encryptor_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic logic [31:0] mix_word(input logic [31:0] v);
    return ((v << 4) ^ ((v >> 5) & 32'h07ff_ffff)) + v;
  endfunction

  task automatic predict_chars(input logic [7:0] b, input logic last);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
    logic [7:0]  cb;
    xtea_out_t   c;
    plain_block[plain_fill] = b;
    plain_fill++;
    if (plain_fill == BLOCK_LEN || last) begin
      v0 = {plain_block[3], plain_block[2], plain_block[1], plain_block[0]};
      v1 = {plain_block[7], plain_block[6], plain_block[5], plain_block[4]};
      sum = '0;
      for (int r = 0; r < ROUND_CYCLES; r++) begin
        v0 = v0 + (mix_word(v1) ^ (sum + cipher_key[sum[1:0]]));
        sum = sum + cipher_delta;
        v1 = v1 + (mix_word(v0) ^ (sum + cipher_key[sum[12:11]]));
      end
      c.out_last = 1'b0;
      for (int i = 0; i < 8; i++) begin
        cb = (i < 4) ? v0[8*i +: 8] : v1[8*(i-4) +: 8];
        c.out_char = NIBBLE_BASE + {4'h0, cb[7:4]};
        expected_chars.push_back(c);
        c.out_char = NIBBLE_BASE + {4'h0, cb[3:0]};
        expected_chars.push_back(c);
      end
      for (int i = 0; i < 8; i++) begin
        plain_block[i] = '0;
      end
      plain_fill = 0;
    end
    if (last) begin
      c.out_char = TERMINATOR;
      c.out_last = 1'b1;
      expected_chars.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                  out_data.out_char, out_data.out_last));
      end else begin
        if (out_data.out_char !== expected_chars[0].out_char) begin
          report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                    out_data.out_char, expected_chars[0].out_char));
        end
        if (out_data.out_last !== expected_chars[0].out_last) begin
          report_mismatch($sformatf("out_last %0b, expected %0b",
                                    out_data.out_last, expected_chars[0].out_last));
        end
        void'(expected_chars.pop_front());
        chars_checked++;
      end
    end
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_seen != hold_total) begin
      hold_seen <= hold_total;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: begin
          out_ready <= 1'b1;
        end
        RX_RANDOM: begin
          out_ready <= ($urandom_range(0, 9) < 6);
        end
        default: begin
          out_ready <= ((rx_tick % 7) < 4);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    run_cycles++;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT || run_cycles >= RUN_LIMIT) begin
      $display("Timeout after %0d cycles, %0d chars still expected",
               run_cycles, expected_chars.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    xtea_in_t item;
    item.in_byte = b;
    item.in_last = last;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predict_chars(b, last);
    bytes_sent++;
    if (last) begin
      msgs_sent++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else if (!gapless) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 6);
    end
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(rand_byte(), i == len - 1);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DELTA) begin
      cipher_delta = val;
    end else if (idx <= REG_KEY3) begin
      cipher_key[2'(idx - REG_KEY0)] = val;
    end
    cfg_writes++;
  endtask

  task automatic write_config(input logic [31:0] vals [5], input logic [4:0] mask,
                              input int junk);
    wait_drain();
    for (int i = 0; i < 5; i++) begin
      if (mask[i]) begin
        write_reg(REG_DELTA + CFG_INDEX_W'(i), vals[i]);
      end
    end
    for (int i = 0; i < junk; i++) begin
      write_reg(CFG_INDEX_W'($urandom_range(REG_KEY3 + 1, REG_LAST_INDEX)), $urandom());
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    logic [7:0] pattern [8];
    pattern = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
    for (int i = 0; i < 8; i++) begin
      send_byte(pattern[i], 1'b0);
    end
    send_byte(8'h3C, 1'b1);
    for (int i = 0; i < 8; i++) begin
      send_byte(8'hFF, i == 7);
    end
  endtask

  task automatic test_config_extremes();
    logic [31:0] vals [5];
    vals = '{32'h9E37_79B9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    write_config(vals, 5'b11111, 1);
    for (int i = 0; i < 4; i++) begin
      send_byte(8'h00, i == 3);
    end
    vals = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
    write_config(vals, 5'b11111, 3);
    send_message(3);
  endtask

  task automatic test_backpressure();
    wait_drain();
    rx_mode <= RX_ALWAYS;
    gapless = 1'b1;
    hold_total <= hold_total + 1;
    for (int m = 0; m < 5; m++) begin
      send_message($urandom_range(4, 12));
    end
    gapless = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [31:0] vals [5];
    int          start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      for (int i = 0; i < 5; i++) begin
        vals[i] = rand_word();
      end
      write_config(vals, 5'($urandom_range(1, 31)), $urandom_range(0, 2));
      rx_mode <= rx_mode_t'($urandom_range(RX_ALWAYS, RX_PATTERN));
      repeat ($urandom_range(3, 6)) begin
        send_message(($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) :
                                                   $urandom_range(1, 16));
      end
    end
  endtask

  initial begin
    cipher_delta = DELTA_RESET;
    cipher_key = '{KEY0_RESET, KEY1_RESET, KEY2_RESET, KEY3_RESET};
    for (int i = 0; i < 8; i++) begin
      plain_block[i] = '0;
    end
    plain_fill = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));
    end

    $display("Covered %0d bytes in %0d messages, %0d characters checked, %0d register writes.",
             bytes_sent, msgs_sent, chars_checked, cfg_writes);
    $display("Included reset keys, extreme keys and deltas, ignored indexes and a long hold-off.");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
